### rtl/core/fqme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqme_pkg
// Shared types, constants and index helpers for the min-eviction FIFO.
// ----------------------------------------------------------------------------
package fqme_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int FILL_W   = 5;
	localparam int STAT_W   = 3;

	localparam logic signed [DATA_W-1:0] NO_DATA = -32'sd1;

	typedef enum logic [STAT_W-1:0] {
		ST_STORED  = 3'd0,
		ST_EVICTED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_POPPED  = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_TAIL,
		S_RESP
	} state_t;

	// Control into the shared compare unit.
	typedef struct packed {
		logic init;
		logic step;
	} scan_ctl_t;

	// Running extremes held by the compare unit.
	typedef struct packed {
		logic signed [DATA_W-1:0] max;
		logic signed [DATA_W-1:0] min;
		logic [IDX_W-1:0]         minpos;
	} scan_res_t;

	// Physical slot of a logical offset from the head, wrapping at CAPACITY.
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/fqme_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqme_req_if
// Request channel: push/pop mode and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqme_req_if;
	import fqme_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);

endinterface
`default_nettype wire

### rtl/core/fqme_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqme_rsp_if
// Response channel: status, data and fill, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqme_rsp_if;
	import fqme_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] data;
	logic [FILL_W-1:0]        fill;

	modport source (output valid, output status, output data, output fill, input ready);
	modport sink (input valid, input status, input data, input fill, output ready);

endinterface
`default_nettype wire

### rtl/core/fqme_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqme_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqme_store
	import fqme_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [IDX_W-1:0]         waddr,
	input  wire logic signed [DATA_W-1:0] wdata,
	input  wire logic [IDX_W-1:0]         raddr,
	output logic signed [DATA_W-1:0]      rdata
);

	logic signed [DATA_W-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/fqme_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqme_scan
// Shared signed comparator with running max / min / min-position registers.
// ----------------------------------------------------------------------------
module fqme_scan
	import fqme_pkg::*;
(
	input  wire logic                     clk,
	input  wire scan_ctl_t                ctl,
	input  wire logic signed [DATA_W-1:0] elem,
	input  wire logic [IDX_W-1:0]         pos,
	output logic                          gt_max,
	output scan_res_t                     res
);

	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] min_q;
	logic [IDX_W-1:0]         minpos_q;
	logic                     lt_min;

	// gt_max doubles as the final "beats every entry" test.
	assign gt_max = elem > max_q;
	assign lt_min = elem < min_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			max_q    <= elem;
			min_q    <= elem;
			minpos_q <= pos;
		end else if (ctl.step) begin
			if (gt_max) begin
				max_q <= elem;
			end
			if (lt_min) begin
				min_q    <= elem;
				minpos_q <= pos;
			end
		end
	end

	assign res.max    = max_q;
	assign res.min    = min_q;
	assign res.minpos = minpos_q;

endmodule
`default_nettype wire

### rtl/core/fifo_with_min_eviction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_min_eviction
// Bounded FIFO of signed 32-bit values that evicts the oldest minimum when
// a larger-than-everything value arrives at a full queue.
// ----------------------------------------------------------------------------
// One request beat gives exactly one response beat. A push with room and a pop
// of an empty queue are answered straight from the idle state; a pop goes
// through the memory read, then the response hold stage. A push into a full
// queue scans every entry through the single memory read port, then takes a
// decision: it is dropped and goes to the response stage, or it evicts, and
// the CAPACITY-1-minpos later entries are copied down one place, one tail
// write follows, then the response stage. Both passes walk the one read port
// of the entry memory one entry per cycle; the scan pass feeds every entry to
// the one shared compare unit.
// The block takes one request at a time; req.ready is high only when the
// sequencer is idle and the response register is free or being drained.
// The entry memory has no reset: read data is used only from stored slots.
// ----------------------------------------------------------------------------
module fifo_with_min_eviction
	import fqme_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	fqme_req_if.sink    req,
	fqme_rsp_if.source  rsp
);

	// sequencer
	state_t state_q, state_d;

	// queue pointers
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] occ_q, occ_d;

	// pass counter and read-tracking stage
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rv_s1, rv_d;
	logic [IDX_W-1:0] rpos_s1, rpos_d;

	// latched request value and pending result
	logic signed [DATA_W-1:0] x_q, x_d;
	status_t                  res_status_q, res_status_d;
	logic signed [DATA_W-1:0] res_data_q, res_data_d;

	// response register
	logic                     out_v_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [FILL_W-1:0]        out_fill_q;
	logic                     out_ld;
	status_t                  ld_status;
	logic signed [DATA_W-1:0] ld_data;
	logic [FILL_W-1:0]        ld_fill;
	logic                     out_free;

	// memory ports
	logic                     we;
	logic [IDX_W-1:0]         waddr;
	logic signed [DATA_W-1:0] wdata;
	logic [IDX_W-1:0]         raddr;
	logic signed [DATA_W-1:0] rdata;

	// compare unit
	scan_ctl_t                scan_ctl;
	logic signed [DATA_W-1:0] scan_elem;
	logic                     scan_gt;
	scan_res_t                scan_res;

	logic req_fire;

	fqme_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	fqme_scan u_scan (
		.clk    (clk),
		.ctl    (scan_ctl),
		.elem   (scan_elem),
		.pos    (rpos_s1),
		.gt_max (scan_gt),
		.res    (scan_res)
	);

	assign out_free = !out_v_q || rsp.ready;
	assign req_fire = req.valid && req.ready;

	// During the decision the comparator sees the new value against the max;
	// during the scan it sees each entry coming back from memory.
	assign scan_elem = (state_q == S_DECIDE) ? x_q : rdata;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		occ_d        = occ_q;
		cnt_d        = cnt_q;
		rv_d         = 1'b0;
		rpos_d       = rpos_s1;
		x_d          = x_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		we           = 1'b0;
		waddr        = head_q;
		wdata        = x_q;
		raddr        = head_q;
		scan_ctl     = '0;
		out_ld       = 1'b0;
		ld_status    = ST_STORED;
		ld_data      = NO_DATA;
		ld_fill      = FILL_W'(occ_q);
		req.ready    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = out_free;
				if (req_fire) begin
					x_d = req.value;
					if (req.mode) begin
						if (occ_q == '0) begin
							out_ld    = 1'b1;
							ld_status = ST_EMPTY;
							ld_fill   = '0;
						end else begin
							// front entry read is issued at head this cycle
							occ_d   = occ_q - 1'b1;
							head_d  = (occ_q == CNT_W'(1)) ? '0 : slot(head_q, IDX_W'(1));
							state_d = S_POP;
						end
					end else if (occ_q < CNT_W'(CAPACITY)) begin
						we        = 1'b1;
						waddr     = slot(head_q, occ_q[IDX_W-1:0]);
						wdata     = req.value;
						occ_d     = occ_q + 1'b1;
						out_ld    = 1'b1;
						ld_status = ST_STORED;
						ld_fill   = FILL_W'(occ_q + 1'b1);
					end else begin
						cnt_d   = '0;
						state_d = S_SCAN;
					end
				end
			end

			S_POP: begin
				res_status_d = ST_POPPED;
				res_data_d   = rdata;
				state_d      = S_RESP;
			end

			S_SCAN: begin
				if (cnt_q < CNT_W'(CAPACITY)) begin
					raddr  = slot(head_q, cnt_q[IDX_W-1:0]);
					rv_d   = 1'b1;
					rpos_d = cnt_q[IDX_W-1:0];
					cnt_d  = cnt_q + 1'b1;
				end
				if (rv_s1) begin
					scan_ctl.init = (rpos_s1 == '0);
					scan_ctl.step = (rpos_s1 != '0);
				end
				if (cnt_q == CNT_W'(CAPACITY) && !rv_s1) begin
					state_d = S_DECIDE;
				end
			end

			S_DECIDE: begin
				if (scan_gt) begin
					res_status_d = ST_EVICTED;
					res_data_d   = scan_res.min;
					cnt_d        = CNT_W'(scan_res.minpos) + 1'b1;
					state_d      = S_SHIFT;
				end else begin
					res_status_d = ST_DROPPED;
					res_data_d   = NO_DATA;
					state_d      = S_RESP;
				end
			end

			S_SHIFT: begin
				// read offset j+1 now, write it back at offset j in the cycle after
				if (cnt_q < CNT_W'(CAPACITY)) begin
					raddr  = slot(head_q, cnt_q[IDX_W-1:0]);
					rv_d   = 1'b1;
					rpos_d = cnt_q[IDX_W-1:0];
					cnt_d  = cnt_q + 1'b1;
				end
				if (rv_s1) begin
					we    = 1'b1;
					waddr = slot(head_q, rpos_s1 - IDX_W'(1));
					wdata = rdata;
				end
				if (cnt_q == CNT_W'(CAPACITY) && !rv_s1) begin
					state_d = S_TAIL;
				end
			end

			S_TAIL: begin
				we      = 1'b1;
				waddr   = slot(head_q, IDX_W'(CAPACITY - 1));
				wdata   = x_q;
				state_d = S_RESP;
			end

			S_RESP: begin
				if (out_free) begin
					out_ld    = 1'b1;
					ld_status = res_status_q;
					ld_data   = res_data_q;
					ld_fill   = FILL_W'(occ_q);
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			rv_s1   <= rv_d;
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rpos_s1      <= rpos_d;
		x_q          <= x_d;
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		if (out_ld) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_fill_q   <= ld_fill;
		end
	end

	assign rsp.valid  = out_v_q;
	assign rsp.status = out_status_q;
	assign rsp.data   = out_data_q;
	assign rsp.fill   = out_fill_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// occupancy never runs past the capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	// the scan pass never writes the memory
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !we)
		else $error("memory write during scan");

	// the decision sees a complete scan
	a_decide_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECIDE |-> (cnt_q == CNT_W'(CAPACITY) && !rv_s1))
		else $error("decision before scan finished");

	// a pop of a non-empty queue goes to the read-wait state
	a_pop_path: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.mode && occ_q != '0) |=> state_q == S_POP)
		else $error("pop did not enter read wait");

	// a response waiting to be taken is never overwritten
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |-> !out_ld)
		else $error("response register overwritten");

endmodule
`default_nettype wire
